### design/cau_pkg.sv
// shared types and constants for the complex arithmetic unit
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned QUOT_W    = 33;
  localparam int unsigned DIV_STEPS = QUOT_W;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     overflow;
    logic                     div_by_zero;
  } out_beat_t;

endpackage
`default_nettype wire

### design/cau_stream_ifs.sv
// valid/ready channels for operand and result beats
`default_nettype none
interface cau_in_if;
  logic              valid;
  logic              ready;
  cau_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  cau_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/complex_arith_unit.sv
// pipelined complex add, subtract, multiply and divide on signed fixed point
//
//  channel | dir | beat
//  in_if   | in  | mode, a_re, a_im, b_re, b_im
//  out_if  | out | res_re, res_im, overflow, div_by_zero
//
//  one beat per cycle in every mode while the output register is empty or taken; every mode passes all stages
//  stages: products, sums, setup, 33 restoring quotient steps, output register
//  the whole pipeline advances when the output register is empty or taken
//  synchronous active-low reset clears the valid bits only
`default_nettype none
module complex_arith_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cau_in_if.sink    in_if,
  cau_out_if.source out_if
);

  localparam int unsigned W     = cau_pkg::DATA_W;
  localparam int unsigned QW    = cau_pkg::QUOT_W;
  localparam int unsigned NST   = cau_pkg::DIV_STEPS;
  localparam int unsigned PRE_SH = QW - FRAC_BITS;

  typedef struct packed {
    logic          neg;
    logic          big;
    logic [63:0]   num;
    logic [63:0]   rem;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic [W-1:0]  res_re;
    logic [W-1:0]  res_im;
    logic          ovf;
    logic [63:0]   den;
    lane_t         lre;
    lane_t         lim;
  } dstage_t;

  function automatic lane_t div_step(lane_t l, logic [63:0] den, int bit_idx);
    lane_t       o;
    logic        nb;
    logic [64:0] t;
    o  = l;
    nb = 1'b0;
    if (bit_idx >= int'(FRAC_BITS)) begin
      nb = l.num[bit_idx - int'(FRAC_BITS)];
    end
    t = {l.rem, nb};
    if (t >= {1'b0, den}) begin
      t   = t - {1'b0, den};
      o.q = {l.q[QW-2:0], 1'b1};
    end else begin
      o.q = {l.q[QW-2:0], 1'b0};
    end
    o.rem = t[63:0];
    return o;
  endfunction

  function automatic logic [W:0] sat65(logic signed [64:0] s);
    logic hi_ok;
    hi_ok = (s[64:W-1] == '0) || (s[64:W-1] == '1);
    if (hi_ok) begin
      return {1'b0, s[W-1:0]};
    end else if (s[64]) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  function automatic lane_t lane_init(logic signed [64:0] s, logic [63:0] den);
    lane_t       l;
    logic [64:0] m;
    logic [63:0] r0;
    m      = s[64] ? 65'(-s) : 65'(s);
    r0     = m[63:0] >> PRE_SH;
    l.neg  = s[64];
    l.num  = m[63:0];
    l.big  = (r0 >= den);
    l.rem  = r0;
    l.q    = '0;
    return l;
  endfunction

  function automatic logic [W:0] lane_out(lane_t l);
    logic [QW-1:0] lim;
    logic [QW-1:0] v;
    lim = l.neg ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    if (l.big || (l.q > lim)) begin
      return l.neg ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
    end
    v = l.neg ? QW'(-l.q) : l.q;
    return {1'b0, v[W-1:0]};
  endfunction

  logic en;

  // stage 1: products and add/subtract sums
  logic                     v1_r;
  logic [1:0]               mode1_r;
  logic signed [63:0]       p_rr_r, p_ii_r, p_ri_r, p_ir_r, d_rr_r, d_ii_r;
  logic signed [W:0]        as_re_r, as_im_r;

  // stage 2: sums
  logic                     v2_r;
  logic [1:0]               mode2_r;
  logic signed [64:0]       s_re_r, s_im_r;
  logic [63:0]              den2_r;

  // quotient pipeline
  logic    dv_r [NST+1];
  dstage_t ds_r [NST+1];

  logic      ov_r;
  cau_pkg::out_beat_t ob_r;

  assign en           = !ov_r || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = ov_r;
  assign out_if.data  = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
      for (int k = 0; k <= int'(NST); k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r <= in_if.valid;
      v2_r <= v1_r;
      dv_r[0] <= v2_r;
      for (int k = 0; k < int'(NST); k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      ov_r <= dv_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [64:0] a_re_x, a_im_x, m_re, m_im;
    logic [W:0]         sr, si;
    logic               d_is, d_z;
    dstage_t            d0, dn;
    if (en) begin
      mode1_r <= in_if.data.mode;
      p_rr_r  <= 64'(in_if.data.a_re) * 64'(in_if.data.b_re);
      p_ii_r  <= 64'(in_if.data.a_im) * 64'(in_if.data.b_im);
      p_ri_r  <= 64'(in_if.data.a_re) * 64'(in_if.data.b_im);
      p_ir_r  <= 64'(in_if.data.a_im) * 64'(in_if.data.b_re);
      d_rr_r  <= 64'(in_if.data.b_re) * 64'(in_if.data.b_re);
      d_ii_r  <= 64'(in_if.data.b_im) * 64'(in_if.data.b_im);
      if (in_if.data.mode == cau_pkg::MODE_SUB) begin
        as_re_r <= (W+1)'(in_if.data.a_re) - (W+1)'(in_if.data.b_re);
        as_im_r <= (W+1)'(in_if.data.a_im) - (W+1)'(in_if.data.b_im);
      end else begin
        as_re_r <= (W+1)'(in_if.data.a_re) + (W+1)'(in_if.data.b_re);
        as_im_r <= (W+1)'(in_if.data.a_im) + (W+1)'(in_if.data.b_im);
      end

      mode2_r <= mode1_r;
      den2_r  <= 64'(d_rr_r) + 64'(d_ii_r);
      case (mode1_r)
        cau_pkg::MODE_MUL: begin
          s_re_r <= 65'(p_rr_r) - 65'(p_ii_r);
          s_im_r <= 65'(p_ri_r) + 65'(p_ir_r);
        end
        cau_pkg::MODE_DIV: begin
          s_re_r <= 65'(p_rr_r) + 65'(p_ii_r);
          s_im_r <= 65'(p_ir_r) - 65'(p_ri_r);
        end
        default: begin
          s_re_r <= 65'(as_re_r);
          s_im_r <= 65'(as_im_r);
        end
      endcase

      d_is = (mode2_r == cau_pkg::MODE_DIV);
      d_z  = d_is && (den2_r == '0);
      if (mode2_r == cau_pkg::MODE_MUL) begin
        m_re = s_re_r >>> FRAC_BITS;
        m_im = s_im_r >>> FRAC_BITS;
      end else begin
        m_re = s_re_r;
        m_im = s_im_r;
      end
      a_re_x = m_re;
      a_im_x = m_im;
      sr = sat65(a_re_x);
      si = sat65(a_im_x);
      d0.is_div = d_is;
      d0.dz     = d_z;
      d0.res_re = d_is ? '0 : sr[W-1:0];
      d0.res_im = d_is ? '0 : si[W-1:0];
      d0.ovf    = d_is ? 1'b0 : (sr[W] | si[W]);
      d0.den    = den2_r;
      d0.lre    = lane_init(s_re_r, den2_r);
      d0.lim    = lane_init(s_im_r, den2_r);
      ds_r[0]  <= d0;

      for (int k = 0; k < int'(NST); k++) begin
        dn         = ds_r[k];
        dn.lre     = div_step(ds_r[k].lre, ds_r[k].den, int'(NST) - 1 - k);
        dn.lim     = div_step(ds_r[k].lim, ds_r[k].den, int'(NST) - 1 - k);
        ds_r[k+1] <= dn;
      end

      sr = lane_out(ds_r[NST].lre);
      si = lane_out(ds_r[NST].lim);
      if (ds_r[NST].is_div && ds_r[NST].dz) begin
        ob_r <= '{res_re: '0, res_im: '0, overflow: 1'b0, div_by_zero: 1'b1};
      end else if (ds_r[NST].is_div) begin
        ob_r <= '{res_re: sr[W-1:0], res_im: si[W-1:0], overflow: sr[W] | si[W],
                  div_by_zero: 1'b0};
      end else begin
        ob_r <= '{res_re: ds_r[NST].res_re, res_im: ds_r[NST].res_im,
                  overflow: ds_r[NST].ovf, div_by_zero: 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### tb/complex_arith_unit_test.sv
// self-checking testbench for the complex arithmetic unit: directed table, then random beats
`timescale 1ns / 100ps
module complex_arith_unit_test;

  localparam int N_RANDOM = 1900;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    cau_pkg::in_beat_t  beat;
    bit                 typed;
    cau_pkg::out_beat_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if  in_if ();
  cau_out_if out_if ();

  complex_arith_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always #6 clk = ~clk;

  cau_pkg::out_beat_t pending_q[$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_dz = 0;
  int        n_ovf = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;

  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v, inout bit ovf);
    if (v > 96'sh7FFFFFFF) begin
      ovf = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -96'sh80000000) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [95:0] quot_fix(input logic signed [95:0] num,
                                                  input logic [95:0] den);
    logic [95:0] mag;
    logic [95:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << 16) / den;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_pkg::out_beat_t complex_result(input cau_pkg::in_beat_t b);
    logic signed [95:0] ar, ai, br, bi, re, im;
    logic [95:0] den;
    cau_pkg::out_beat_t r;
    bit ovf;
    ar = b.a_re; ai = b.a_im; br = b.b_re; bi = b.b_im;
    ovf = 1'b0;
    r.div_by_zero = 1'b0;
    case (cau_pkg::mode_t'(b.mode))
      cau_pkg::MODE_ADD: begin
        re = ar + br; im = ai + bi;
      end
      cau_pkg::MODE_SUB: begin
        re = ar - br; im = ai - bi;
      end
      cau_pkg::MODE_MUL: begin
        re = (ar * br - ai * bi) >>> 16;
        im = (ar * bi + ai * br) >>> 16;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
          re = 0; im = 0;
        end else begin
          re = quot_fix(ar * br + ai * bi, den);
          im = quot_fix(ai * br - ar * bi, den);
        end
      end
    endcase
    r.res_re = clamp32(re, ovf);
    r.res_im = clamp32(im, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 32'h80000) - 32'h40000;
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'h10000;
          default: return 32'hFFFFFFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h2000000) - 32'h1000000;
    endcase
  endfunction

  function automatic cau_pkg::in_beat_t random_beat();
    cau_pkg::in_beat_t b;
    b.mode = 2'($urandom_range(0, 3));
    b.a_re = pick_word(); b.a_im = pick_word();
    b.b_re = pick_word(); b.b_im = pick_word();
    if (b.mode == cau_pkg::MODE_DIV && $urandom_range(0, 11) == 0) begin
      b.b_re = '0; b.b_im = '0;
    end
    return b;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // result monitor
  always @(posedge clk) begin
    cau_pkg::out_beat_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_q.size() == 0) begin
        report("unexpected beat", got.res_re, 32'h0);
      end else begin
        want = pending_q.pop_front();
        if (got.res_re !== want.res_re) report("res_re", got.res_re, want.res_re);
        if (got.res_im !== want.res_im) report("res_im", got.res_im, want.res_im);
        if (got.overflow !== want.overflow)
          report("overflow", 32'(got.overflow), 32'(want.overflow));
        if (got.div_by_zero !== want.div_by_zero)
          report("div_by_zero", 32'(got.div_by_zero), 32'(want.div_by_zero));
        n_checked++;
        n_ovf += got.overflow;
        n_dz += got.div_by_zero;
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int stall_pct;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall_pct = $urandom_range(0, 3) * 30;
      repeat ($urandom_range(20, 120)) begin
        if (hold_req) begin
          out_if.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(input cau_pkg::in_beat_t b, input cau_pkg::out_beat_t want);
    in_if.valid <= 1'b1;
    in_if.data <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_q.push_back(want);
    n_sent++;
  endtask

  initial begin
    row_t table_rows[$];
    row_t r;
    cau_pkg::in_beat_t b;
    int burst;
    in_if.valid = 1'b0;
    in_if.data = '0;

    r.typed = 1'b1;
    r.beat = '{cau_pkg::MODE_ADD, 0, 0, 0, 0};
    r.want = '{0, 0, 1'b0, 1'b0}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    r.want = '{32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_SUB, 32'h80000000, 0, 1, 0};
    r.want = '{32'h80000000, 0, 1'b1, 1'b0}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_SUB, 32'h7FFFFFFF, 5, 32'h7FFFFFFF, 5};
    r.want = '{0, 0, 1'b0, 1'b0}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_MUL, 32'h10000, 0, 32'h10000, 0};
    r.want = '{32'h10000, 0, 1'b0, 1'b0}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_MUL, 32'h7FFFFFFF, 32'h80000000, 0, 0};
    r.want = '{0, 0, 1'b0, 1'b0}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_DIV, 32'h12345678, 32'h80000000, 0, 0};
    r.want = '{0, 0, 1'b0, 1'b1}; table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_DIV, 32'h10000, 0, 32'h10000, 0};
    r.want = '{32'h10000, 0, 1'b0, 1'b0}; table_rows.push_back(r);
    r.typed = 1'b0;
    r.beat = '{cau_pkg::MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_MUL, 32'hFFFFFFFF, 1, 1, 32'hFFFFFFFF};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_DIV, 32'h7FFFFFFF, 32'h80000000, 1, 0};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_DIV, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_DIV, 32'hFFFFFFFF, 3, 32'h7FFFFFFF, 32'hFFFFFFFF};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_DIV, 32'h30000, 32'hFFFF0000, 0, 32'h20000};
    table_rows.push_back(r);
    r.beat = '{cau_pkg::MODE_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
    table_rows.push_back(r);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i])
      send_beat(table_rows[i].beat,
                table_rows[i].typed ? table_rows[i].want : complex_result(table_rows[i].beat));

    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 700) hold_req = 1'b1;
      if (n == 1300) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 60);
        if ($urandom_range(0, 2) != 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst--;
      b = random_beat();
      send_beat(b, complex_result(b));
    end
    in_if.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d beats, checked %0d results (%0d saturated, %0d divide by zero)",
             n_sent, n_checked, n_ovf, n_dz);
    $display("covered add, subtract, multiply and divide with field extremes and stalls");
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### complex_arith_unit.f
design/cau_pkg.sv
design/cau_stream_ifs.sv
design/complex_arith_unit.sv
tb/complex_arith_unit_test.sv
